@@ hw/rtl/slpc_pkg.sv @@
// ----------------------------------------------------------------------------
// slpc_pkg - shared types and constants of the status LED pattern controller
// Level constants, timing constants and the attention burst pattern table.
// ----------------------------------------------------------------------------
`default_nettype none

package slpc_pkg;

	typedef logic [6:0] level_t;

	localparam level_t LVL_MIN    = 7'd10;
	localparam level_t LVL_MAX    = 7'd100;
	localparam level_t LVL_STATUS = 7'd35;
	localparam level_t LVL_ATTN   = 7'd75;
	localparam level_t LVL_WARN   = 7'd90;

	localparam logic [7:0] GAP_MS        = 8'd140;
	localparam logic [9:0] PREVIEW_MS    = 10'd1000;
	localparam logic [9:0] USB_WIN_MS    = 10'd650;
	localparam logic [8:0] LIVE_WIN_MS   = 9'd500;
	localparam logic [7:0] REFRESH_MS    = 8'd250;
	localparam logic [6:0] USB_PULSE_MS  = 7'd90;
	localparam logic [6:0] LIVE_PULSE_MS = 7'd70;

	// Phase width: a remainder before correction stays below twice the period
	localparam int PH_W    = 17;
	localparam int RECIP_W = 22;
	localparam int PER_W   = 16;
	localparam int XW      = 32;

	typedef logic [PER_W-1:0]   period_t;
	typedef logic [RECIP_W-1:0] recip_t;

	localparam logic [63:0] TWO32 = 64'd4294967296;
	localparam recip_t RECIP_1800  = RECIP_W'(TWO32 / 64'd1800);
	localparam recip_t RECIP_2500  = RECIP_W'(TWO32 / 64'd2500);
	localparam recip_t RECIP_3000  = RECIP_W'(TWO32 / 64'd3000);
	localparam recip_t RECIP_4000  = RECIP_W'(TWO32 / 64'd4000);
	localparam recip_t RECIP_5000  = RECIP_W'(TWO32 / 64'd5000);
	localparam recip_t RECIP_9000  = RECIP_W'(TWO32 / 64'd9000);
	localparam recip_t RECIP_30000 = RECIP_W'(TWO32 / 64'd30000);
	localparam recip_t RECIP_60000 = RECIP_W'(TWO32 / 64'd60000);

	typedef enum logic [3:0] {
		ATT_IDLE    = 4'd0,
		ATT_NODATA  = 4'd1,
		ATT_HB1     = 4'd2,
		ATT_HB2     = 4'd3,
		ATT_ACTIVE  = 4'd4,
		ATT_ATTN    = 4'd5,
		ATT_CAUTION = 4'd6,
		ATT_WARN    = 4'd7,
		ATT_STALE   = 4'd8,
		ATT_ERROR   = 4'd9
	} attn_t;

	typedef struct packed {
		period_t    period;
		recip_t     recip;
		logic [6:0] dur;
		logic [1:0] count;
		level_t     level;
	} pattern_t;

	function automatic pattern_t pattern_of(attn_t a);
		pattern_t p;
		case (a)
			ATT_ERROR:   p = '{16'd1800,  RECIP_1800,  7'd100, 2'd3, LVL_MAX};
			ATT_STALE:   p = '{16'd30000, RECIP_30000, 7'd80,  2'd3, LVL_WARN};
			ATT_WARN:    p = '{16'd3000,  RECIP_3000,  7'd100, 2'd2, LVL_WARN};
			ATT_CAUTION: p = '{16'd4000,  RECIP_4000,  7'd100, 2'd2, LVL_WARN};
			ATT_ATTN:    p = '{16'd2500,  RECIP_2500,  7'd120, 2'd1, LVL_ATTN};
			ATT_ACTIVE:  p = '{16'd5000,  RECIP_5000,  7'd80,  2'd1, LVL_STATUS};
			ATT_HB1:     p = '{16'd9000,  RECIP_9000,  7'd80,  2'd1, LVL_STATUS};
			ATT_HB2:     p = '{16'd9000,  RECIP_9000,  7'd70,  2'd2, LVL_STATUS};
			ATT_NODATA:  p = '{16'd60000, RECIP_60000, 7'd60,  2'd1, LVL_MIN};
			default:     p = '{16'd1800,  RECIP_1800,  7'd1,   2'd1, 7'd0};
		endcase
		return p;
	endfunction

	// True when the phase falls inside one of the pattern's bursts
	function automatic logic pulse_hit(logic [PH_W-1:0] ph, pattern_t p);
		logic [PH_W-1:0] d;
		logic [PH_W-1:0] st1;
		logic [PH_W-1:0] st2;
		logic            hit;
		d   = PH_W'(p.dur);
		st1 = d + PH_W'(GAP_MS);
		st2 = st1 + st1;
		hit = (ph < d);
		if (p.count >= 2'd2 && ph >= st1 && ph < st1 + d) hit = 1'b1;
		if (p.count >= 2'd3 && ph >= st2 && ph < st2 + d) hit = 1'b1;
		return hit;
	endfunction

	function automatic level_t sat_valid(level_t b);
		level_t r;
		if (b < LVL_MIN)      r = LVL_MIN;
		else if (b > LVL_MAX) r = LVL_MAX;
		else                  r = b;
		return r;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/status_led_pattern_controller_top.sv @@
// ----------------------------------------------------------------------------
// status_led_pattern_controller_top - status LED level per poll
// Tracks transport, keyboard and touch edges and picks the LED level.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one poll per beat; m_axis returns one result beat per poll,
//   in order. cfg_wr_en/cfg_wr_data write live_enable at a rising edge; the user
//   must do so only while the block is idle; the block does not enforce it.
//   Path: a poll accepted on s_axis passes the input register, state update,
//   reciprocal multiply, remainder and result registers on its way to m_axis.
//   Throughput: one poll per cycle while m_axis_tready stays high. The state
//   update reads the input register; the burst phase (time modulo the pattern
//   period) is a constant-reciprocal multiply spread over the following stages.
//   Reset: all flags clear, brightness 100, no pulses armed, attention idle,
//   live_enable set, no beats in flight.
//   Stall: when m_axis_tready is low the result beat holds, and the stages
//   behind it fill up; s_axis_tready falls once every stage holds a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_pattern_controller_top #(
	parameter int TIME_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,   // live_enable

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [31:0] now_ms, [32] usb_selected, [33] keys_active, [34] touched,
	// [41:35] backlight_level, [45:42] attention, [46] new_generation, [47] zero
	input  wire logic [47:0] s_axis_tdata,

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [6:0] led_level, [7] level_changed, [14:8] valid_brightness, [15] zero
	output logic [15:0]      m_axis_tdata
);

	localparam int TW = TIME_BITS;
	localparam int NB = (TIME_BITS < 32) ? TIME_BITS : 32;

	typedef logic [TW-1:0] time_t;

	// ---------------- handshake / stage enables ----------------
	logic v_s1, v_s2, v_s3, v_s4, out_v_q;
	logic en_s1, en_s2, en_s3, en_s4, en_out;

	assign en_out = !out_v_q || m_axis_tready;
	assign en_s4  = !v_s4 || en_out;
	assign en_s3  = !v_s3 || en_s4;
	assign en_s2  = !v_s2 || en_s3;
	assign en_s1  = !v_s1 || en_s2;

	assign s_axis_tready = en_s1;

	// ---------------- stage 1: input register ----------------
	logic [31:0]     now_s1;
	logic            usb_s1, keys_s1, tch_s1, gen_s1;
	slpc_pkg::level_t bl_s1;
	logic [3:0]      att_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_axis_tvalid) begin
			now_s1  <= s_axis_tdata[31:0];
			usb_s1  <= s_axis_tdata[32];
			keys_s1 <= s_axis_tdata[33];
			tch_s1  <= s_axis_tdata[34];
			bl_s1   <= s_axis_tdata[41:35];
			att_s1  <= s_axis_tdata[45:42];
			gen_s1  <= s_axis_tdata[46];
		end
	end

	// ---------------- controller state ----------------
	logic             live_enable_q;
	logic             usb_mode_q, keyboard_on_q, touch_on_q;
	slpc_pkg::level_t good_bright_q, seen_bl_q, shown_level_q;
	time_t            preview_dl_q, usb_start_q, live_start_q, refresh_due_q;
	logic             usb_armed_q, live_armed_q;
	slpc_pkg::attn_t  held_att_q;

	logic             n_usb, n_kb, n_touch, n_uarm, n_larm;
	slpc_pkg::level_t n_good, n_seen, bl_sat, lvl_a;
	time_t            n_pdl, n_ustart, n_lstart, n_rdue;
	time_t            now_t, rd, pd, ue, le;
	slpc_pkg::attn_t  n_held;
	logic             steady, use_pat_a;
	slpc_pkg::pattern_t pat_a;

	always_comb begin
		n_usb    = usb_mode_q;
		n_kb     = keyboard_on_q;
		n_touch  = touch_on_q;
		n_good   = good_bright_q;
		n_seen   = seen_bl_q;
		n_pdl    = preview_dl_q;
		n_ustart = usb_start_q;
		n_uarm   = usb_armed_q;
		n_lstart = live_start_q;
		n_larm   = live_armed_q;
		n_rdue   = refresh_due_q;
		n_held   = held_att_q;
		now_t    = TW'(now_s1[NB-1:0]);
		bl_sat   = slpc_pkg::sat_valid(bl_s1);

		if (usb_s1 != n_usb) begin
			n_usb = usb_s1;
			if (usb_s1) begin
				n_ustart = now_t;
				n_uarm   = 1'b1;
			end
		end
		if (keys_s1 != n_kb) begin
			n_kb = keys_s1;
			if (keys_s1) n_seen = bl_s1;
		end
		if (tch_s1 != n_touch) begin
			n_touch = tch_s1;
			if (tch_s1) begin
				if (n_kb) n_good = bl_sat;
				n_pdl = '0;
			end else begin
				n_pdl = now_t + TW'(slpc_pkg::PREVIEW_MS);
			end
		end
		if (!n_touch && n_kb && bl_s1 != n_seen) begin
			n_seen = bl_s1;
			if (bl_s1 != '0) begin
				n_good = bl_sat;
				n_pdl  = now_t + TW'(slpc_pkg::PREVIEW_MS);
			end else begin
				n_pdl = '0;
			end
		end
		if (gen_s1) begin
			n_lstart = now_t;
			n_larm   = 1'b1;
			n_rdue   = now_t;
		end

		// latch attention at most once per refresh interval, unless a new generation forces it
		rd = n_rdue - now_t;
		if (!(rd != '0 && rd <= TW'(slpc_pkg::REFRESH_MS))) begin
			n_held = slpc_pkg::attn_t'(att_s1);
			n_rdue = now_t + TW'(slpc_pkg::REFRESH_MS);
		end

		pd     = n_pdl - now_t;
		steady = n_touch ||
		         (n_pdl != '0 && pd != '0 && pd <= TW'(slpc_pkg::PREVIEW_MS));
		ue     = now_t - n_ustart;
		le     = now_t - n_lstart;

		use_pat_a = 1'b0;
		lvl_a     = n_good;
		if (!steady) begin
			if (n_uarm && ue >= TW'(slpc_pkg::USB_WIN_MS)) n_uarm = 1'b0;
			if (n_larm && le >= TW'(slpc_pkg::LIVE_WIN_MS)) n_larm = 1'b0;
			if (n_uarm) begin
				// double pulse: second one starts one gap after the first ends
				lvl_a = (ue < TW'(slpc_pkg::USB_PULSE_MS) ||
				         (ue >= TW'(slpc_pkg::USB_PULSE_MS) + TW'(slpc_pkg::GAP_MS) &&
				          ue < TW'(slpc_pkg::USB_PULSE_MS) + TW'(slpc_pkg::GAP_MS) +
				               TW'(slpc_pkg::USB_PULSE_MS)))
				        ? slpc_pkg::LVL_MAX : '0;
			end else if (!live_enable_q) begin
				lvl_a = '0;
			end else if (n_larm) begin
				lvl_a = (le < TW'(slpc_pkg::LIVE_PULSE_MS)) ? slpc_pkg::LVL_ATTN : '0;
			end else begin
				lvl_a     = '0;
				use_pat_a = 1'b1;
			end
		end

		pat_a = slpc_pkg::pattern_of(n_held);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_enable_q <= 1'b1;
			usb_mode_q    <= 1'b0;
			keyboard_on_q <= 1'b0;
			touch_on_q    <= 1'b0;
			good_bright_q <= slpc_pkg::LVL_MAX;
			seen_bl_q     <= '0;
			preview_dl_q  <= '0;
			usb_start_q   <= '0;
			usb_armed_q   <= 1'b0;
			live_start_q  <= '0;
			live_armed_q  <= 1'b0;
			refresh_due_q <= '0;
			held_att_q    <= slpc_pkg::ATT_IDLE;
		end else begin
			if (cfg_wr_en) live_enable_q <= cfg_wr_data;
			if (v_s1 && en_s2) begin
				usb_mode_q    <= n_usb;
				keyboard_on_q <= n_kb;
				touch_on_q    <= n_touch;
				good_bright_q <= n_good;
				seen_bl_q     <= n_seen;
				preview_dl_q  <= n_pdl;
				usb_start_q   <= n_ustart;
				usb_armed_q   <= n_uarm;
				live_start_q  <= n_lstart;
				live_armed_q  <= n_larm;
				refresh_due_q <= n_rdue;
				held_att_q    <= n_held;
			end
		end
	end

	// ---------------- stages 2..4: burst phase ----------------
	logic [slpc_pkg::XW-1:0] x_s2, x_s3;
	slpc_pkg::pattern_t      pat_s2, pat_s3, pat_s4;
	logic                    use_pat_s2, use_pat_s3, use_pat_s4;
	slpc_pkg::level_t        lvl_s2, lvl_s3, lvl_s4;
	slpc_pkg::level_t        good_s2, good_s3, good_s4;
	logic [slpc_pkg::XW+slpc_pkg::RECIP_W-1:0] prod_s3;
	logic [slpc_pkg::PH_W-1:0] ph0_s4;

	logic [slpc_pkg::RECIP_W-1:0]                  quo;
	logic [slpc_pkg::RECIP_W+slpc_pkg::PER_W-1:0]  qc;
	logic [slpc_pkg::PH_W-1:0]                     ph0_c, ph_d;
	slpc_pkg::level_t                              lvl_d;

	// quotient estimate is exact or one short; the remainder is below 2*period
	assign quo   = prod_s3[slpc_pkg::XW +: slpc_pkg::RECIP_W];
	assign qc    = (slpc_pkg::RECIP_W+slpc_pkg::PER_W)'(quo) *
	               (slpc_pkg::RECIP_W+slpc_pkg::PER_W)'(pat_s3.period);
	assign ph0_c = x_s3[slpc_pkg::PH_W-1:0] - qc[slpc_pkg::PH_W-1:0];

	always_comb begin
		if (ph0_s4 >= slpc_pkg::PH_W'(pat_s4.period))
			ph_d = ph0_s4 - slpc_pkg::PH_W'(pat_s4.period);
		else
			ph_d = ph0_s4;
		if (use_pat_s4)
			lvl_d = slpc_pkg::pulse_hit(ph_d, pat_s4) ? pat_s4.level : '0;
		else
			lvl_d = lvl_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
			out_v_q       <= 1'b0;
			shown_level_q <= '0;
		end else begin
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_out) begin
				out_v_q <= v_s4;
				if (v_s4) shown_level_q <= lvl_d;
			end
		end
	end

	logic [6:0] led_q, vb_q;
	logic       chg_q;

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			x_s2       <= slpc_pkg::XW'(now_s1[NB-1:0]);
			pat_s2     <= pat_a;
			use_pat_s2 <= use_pat_a;
			lvl_s2     <= lvl_a;
			good_s2    <= n_good;
		end
		if (en_s3 && v_s2) begin
			x_s3       <= x_s2;
			prod_s3    <= (slpc_pkg::XW+slpc_pkg::RECIP_W)'(x_s2) *
			              (slpc_pkg::XW+slpc_pkg::RECIP_W)'(pat_s2.recip);
			pat_s3     <= pat_s2;
			use_pat_s3 <= use_pat_s2;
			lvl_s3     <= lvl_s2;
			good_s3    <= good_s2;
		end
		if (en_s4 && v_s3) begin
			ph0_s4     <= ph0_c;
			pat_s4     <= pat_s3;
			use_pat_s4 <= use_pat_s3;
			lvl_s4     <= lvl_s3;
			good_s4    <= good_s3;
		end
		if (en_out && v_s4) begin
			led_q <= lvl_d;
			chg_q <= (lvl_d != shown_level_q);
			vb_q  <= good_s4;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {1'b0, vb_q, chg_q, led_q};

endmodule

`default_nettype wire
